// ----- rtl/core/dsm_pkg.sv -----
// ----------------------------------------------------------------------------
// dsm_pkg
// Shared types and codes for the dual stack with sorted even merge.
// ----------------------------------------------------------------------------
package dsm_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;

  // opcodes
  localparam logic [2:0] OP_PUSH_A = 3'd0;
  localparam logic [2:0] OP_POP_A  = 3'd1;
  localparam logic [2:0] OP_PUSH_B = 3'd2;
  localparam logic [2:0] OP_POP_B  = 3'd3;
  localparam logic [2:0] OP_MERGE  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_DROP  = 2'd3;

  // what one cell loads next
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_PREV,
    CELL_NEXT,
    CELL_NEW
  } cell_sel_t;

  // what a whole row does next
  typedef enum logic [2:0] {
    ROW_HOLD,
    ROW_PUSH,
    ROW_POP,
    ROW_ROTATE,
    ROW_INSERT
  } row_op_t;

  typedef struct packed {
    logic [DATA_W-1:0] popped;
    logic [1:0]        status;
    logic [DATA_W-1:0] a_top;
    logic              a_empty;
    logic              b_empty;
    logic [CNT_W-1:0]  odd;
    logic [CNT_W-1:0]  bfill;
  } result_t;

endpackage

// ----- rtl/core/dsm_cell.sv -----
// ----------------------------------------------------------------------------
// dsm_cell
// One stack slot: holds a value, loads from either neighbor or a new value,
// and compares its value against the probe.
// ----------------------------------------------------------------------------
module dsm_cell (
  input  logic                      clk,
  input  dsm_pkg::cell_sel_t        sel,
  input  logic [dsm_pkg::DATA_W-1:0] prev,
  input  logic [dsm_pkg::DATA_W-1:0] next,
  input  logic [dsm_pkg::DATA_W-1:0] new_val,
  output logic [dsm_pkg::DATA_W-1:0] value,
  output logic [dsm_pkg::DATA_W-1:0] value_next,
  output logic                      ge
);

  always_comb begin
    unique case (sel)
      dsm_pkg::CELL_PREV: value_next = prev;
      dsm_pkg::CELL_NEXT: value_next = next;
      dsm_pkg::CELL_NEW:  value_next = new_val;
      default:            value_next = value;
    endcase
  end

  assign ge = $signed(value) >= $signed(new_val);

  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ----- rtl/core/dsm_row.sv -----
// ----------------------------------------------------------------------------
// dsm_row
// A row of stack cells, top at cell 0. Supports push, pop, rotate of the
// filled part, and sorted insert ahead of the first entry >= the new value.
// ----------------------------------------------------------------------------
module dsm_row #(
  parameter int DEPTH = 16
) (
  input  logic                              clk,
  input  dsm_pkg::row_op_t                  op,
  input  logic [$clog2(DEPTH+1)-1:0]        fill,
  input  logic [dsm_pkg::DATA_W-1:0]        new_val,
  output logic [dsm_pkg::DATA_W-1:0]        top,
  output logic [dsm_pkg::DATA_W-1:0]        top_next
);

  localparam int FW     = $clog2(DEPTH + 1);
  localparam int LEVELS = $clog2(DEPTH);

  logic [dsm_pkg::DATA_W-1:0] value      [DEPTH];
  logic [dsm_pkg::DATA_W-1:0] value_next [DEPTH];
  logic [DEPTH-1:0]           ge;
  logic [DEPTH-1:0]           occupied;
  logic [DEPTH-1:0]           ge_v;
  logic [DEPTH-1:0]           hit;
  logic [DEPTH-1:0]           pre [LEVELS+1];

  assign ge_v = ge & occupied;

  // hit[i]: some occupied cell above i already holds an entry >= new value
  always_comb begin
    pre[0] = {ge_v[DEPTH-2:0], 1'b0};
    for (int k = 0; k < LEVELS; k++) begin
      pre[k+1] = pre[k] | (pre[k] << (2 ** k));
    end
  end
  assign hit = pre[LEVELS];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [FW-1:0] IDX  = FW'(i);
    localparam logic [FW-1:0] IDX1 = FW'(i + 1);

    dsm_pkg::cell_sel_t         sel;
    logic [dsm_pkg::DATA_W-1:0] prev;
    logic [dsm_pkg::DATA_W-1:0] next;

    assign occupied[i] = IDX < fill;

    if (i == 0) begin : g_first
      assign prev = value[0];
    end else begin : g_prev
      assign prev = value[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next = value[i];
    end else begin : g_next
      assign next = value[i+1];
    end

    always_comb begin
      unique case (op)
        dsm_pkg::ROW_PUSH: sel = (i == 0) ? dsm_pkg::CELL_NEW : dsm_pkg::CELL_PREV;
        dsm_pkg::ROW_POP:  sel = dsm_pkg::CELL_NEXT;
        dsm_pkg::ROW_ROTATE: begin
          // old top wraps around to the bottom of the filled part
          if (IDX1 == fill) begin
            sel = dsm_pkg::CELL_NEW;
          end else if (IDX1 < fill) begin
            sel = dsm_pkg::CELL_NEXT;
          end else begin
            sel = dsm_pkg::CELL_HOLD;
          end
        end
        dsm_pkg::ROW_INSERT: begin
          if (hit[i]) begin
            sel = dsm_pkg::CELL_PREV;
          end else if (ge_v[i] || !occupied[i]) begin
            sel = dsm_pkg::CELL_NEW;
          end else begin
            sel = dsm_pkg::CELL_HOLD;
          end
        end
        default: sel = dsm_pkg::CELL_HOLD;
      endcase
    end

    dsm_cell u_cell (
      .clk        (clk),
      .sel        (sel),
      .prev       (prev),
      .next       (next),
      .new_val    (new_val),
      .value      (value[i]),
      .value_next (value_next[i]),
      .ge         (ge[i])
    );
  end

  assign top      = value[0];
  assign top_next = value_next[0];

endmodule

// ----- rtl/core/dual_stack_with_sorted_even_merge.sv -----
// ----------------------------------------------------------------------------
// dual_stack_with_sorted_even_merge
// Two bounded LIFO stacks of signed 32-bit values with a sorted even merge.
// ----------------------------------------------------------------------------
// Push, pop and unused opcodes each yield one result beat, registered into
// the output buffer; so does merge when A is empty. Otherwise merge's
// accepting cycle loads the walk, then stack A, a row of cells, rotates by
// one entry per cycle, and each even entry leaving its top is inserted into
// the B row in that same cycle, or dropped if B is full, so A's fill sets
// the merge length. A two-entry output buffer lets a new input beat
// be taken while one result waits on a stall.
module dual_stack_with_sorted_even_merge #(
  parameter int STACK_DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     item_valid,
  output logic                     item_stall,
  input  logic [2:0]               opcode,
  input  logic signed [31:0]       data_value,
  output logic                     result_valid,
  input  logic                     result_stall,
  output logic signed [31:0]       popped_value,
  output logic [1:0]               status,
  output logic signed [31:0]       a_top,
  output logic                     a_is_empty,
  output logic                     b_is_empty,
  output logic [4:0]               odd_in_a,
  output logic [4:0]               b_fill
);

  localparam int FW = $clog2(STACK_DEPTH + 1);
  localparam logic [FW-1:0] FULL = FW'(STACK_DEPTH);
  localparam logic [FW-1:0] ONE  = FW'(1);

  typedef enum logic {
    S_IDLE,
    S_MERGE
  } state_t;

  state_t state, state_next;

  logic [FW-1:0] a_cnt, a_cnt_next;
  logic [FW-1:0] b_cnt, b_cnt_next;
  logic [FW-1:0] odd_cnt, odd_cnt_next;
  logic [FW-1:0] left, left_next;
  logic          drop, drop_next;

  dsm_pkg::row_op_t           a_op, b_op;
  logic [dsm_pkg::DATA_W-1:0] a_new, b_new;
  logic [dsm_pkg::DATA_W-1:0] a_top_q, a_top_nx, b_top_q, b_top_nx;

  dsm_pkg::result_t res, held, skid;
  logic             res_fire, skid_valid, accept, out_free;

  assign item_stall = (state == S_MERGE) || skid_valid;
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;

  dsm_row #(.DEPTH(STACK_DEPTH)) u_row_a (
    .clk      (clk),
    .op       (a_op),
    .fill     (a_cnt),
    .new_val  (a_new),
    .top      (a_top_q),
    .top_next (a_top_nx)
  );

  dsm_row #(.DEPTH(STACK_DEPTH)) u_row_b (
    .clk      (clk),
    .op       (b_op),
    .fill     (b_cnt),
    .new_val  (b_new),
    .top      (b_top_q),
    .top_next (b_top_nx)
  );

  always_comb begin
    state_next   = state;
    a_cnt_next   = a_cnt;
    b_cnt_next   = b_cnt;
    odd_cnt_next = odd_cnt;
    left_next    = left;
    drop_next    = drop;
    a_op         = dsm_pkg::ROW_HOLD;
    b_op         = dsm_pkg::ROW_HOLD;
    a_new        = data_value;
    b_new        = data_value;
    res_fire     = 1'b0;
    res          = '0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_fire = 1'b1;
          unique case (opcode)
            dsm_pkg::OP_PUSH_A: begin
              if (a_cnt == FULL) begin
                res.status = dsm_pkg::ST_FULL;
              end else begin
                a_op       = dsm_pkg::ROW_PUSH;
                a_cnt_next = a_cnt + ONE;
                if (data_value[0]) odd_cnt_next = odd_cnt + ONE;
              end
            end
            dsm_pkg::OP_POP_A: begin
              if (a_cnt == '0) begin
                res.status = dsm_pkg::ST_EMPTY;
              end else begin
                a_op       = dsm_pkg::ROW_POP;
                a_cnt_next = a_cnt - ONE;
                res.popped = a_top_q;
                if (a_top_q[0] && odd_cnt != '0) odd_cnt_next = odd_cnt - ONE;
              end
            end
            dsm_pkg::OP_PUSH_B: begin
              if (b_cnt == FULL) begin
                res.status = dsm_pkg::ST_FULL;
              end else begin
                b_op       = dsm_pkg::ROW_PUSH;
                b_cnt_next = b_cnt + ONE;
              end
            end
            dsm_pkg::OP_POP_B: begin
              if (b_cnt == '0) begin
                res.status = dsm_pkg::ST_EMPTY;
              end else begin
                b_op       = dsm_pkg::ROW_POP;
                b_cnt_next = b_cnt - ONE;
                res.popped = b_top_q;
              end
            end
            dsm_pkg::OP_MERGE: begin
              if (a_cnt != '0) begin
                res_fire   = 1'b0;
                state_next = S_MERGE;
                left_next  = a_cnt;
                drop_next  = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      S_MERGE: begin
        a_op  = dsm_pkg::ROW_ROTATE;
        a_new = a_top_q;
        if (!a_top_q[0]) begin
          if (b_cnt != FULL) begin
            b_op       = dsm_pkg::ROW_INSERT;
            b_new      = a_top_q;
            b_cnt_next = b_cnt + ONE;
          end else begin
            drop_next = 1'b1;
          end
        end
        left_next = left - ONE;
        if (left == ONE) begin
          res_fire   = 1'b1;
          res.status = drop_next ? dsm_pkg::ST_DROP : dsm_pkg::ST_OK;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    res.a_top   = (a_cnt_next == '0) ? '0 : a_top_nx;
    res.a_empty = (a_cnt_next == '0);
    res.b_empty = (b_cnt_next == '0);
    res.odd     = dsm_pkg::CNT_W'(odd_cnt_next);
    res.bfill   = dsm_pkg::CNT_W'(b_cnt_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      a_cnt        <= '0;
      b_cnt        <= '0;
      odd_cnt      <= '0;
      left         <= '0;
      drop         <= 1'b0;
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else begin
      state   <= state_next;
      a_cnt   <= a_cnt_next;
      b_cnt   <= b_cnt_next;
      odd_cnt <= odd_cnt_next;
      left    <= left_next;
      drop    <= drop_next;
      // output beat register with a one-entry skid behind it
      if (out_free) begin
        if (skid_valid) begin
          held         <= skid;
          result_valid <= 1'b1;
          skid_valid   <= res_fire;
          if (res_fire) skid <= res;
        end else begin
          result_valid <= res_fire;
          if (res_fire) held <= res;
        end
      end else if (res_fire) begin
        skid       <= res;
        skid_valid <= 1'b1;
      end
    end
  end

  assign popped_value = held.popped;
  assign status       = held.status;
  assign a_top        = held.a_top;
  assign a_is_empty   = held.a_empty;
  assign b_is_empty   = held.b_empty;
  assign odd_in_a     = held.odd;
  assign b_fill       = held.bfill;

  // skid only fills behind a held beat
  a_skid_behind: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> result_valid)
    else $error("skid beat without a held beat");

  // merge leaves A's fill and its odd count untouched
  a_merge_keeps_a: assert property (@(posedge clk) disable iff (rst)
    state == S_MERGE |=> (a_cnt == $past(a_cnt)) && (odd_cnt == $past(odd_cnt)))
    else $error("stack A changed during merge");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (a_cnt <= FULL) && (b_cnt <= FULL) && (odd_cnt <= a_cnt))
    else $error("fill count out of range");

  // B grows by at most one entry per merge step
  a_merge_b_step: assert property (@(posedge clk) disable iff (rst)
    state == S_MERGE |=> (b_cnt == $past(b_cnt)) || (b_cnt == $past(b_cnt) + ONE))
    else $error("B fill jumped during merge");

endmodule

// ----- tb/dsm_stack_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dsm_stack_checker
// Watches both channels of the dual stack, keeps its own copy of the two
// stacks and the odd count, and compares every result beat field by field.
// ----------------------------------------------------------------------------
module dsm_stack_checker #(
  parameter int DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  input  logic               item_stall,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] data_value,
  input  logic               result_valid,
  input  logic               result_stall,
  input  logic signed [31:0] popped_value,
  input  logic [1:0]         status,
  input  logic signed [31:0] a_top,
  input  logic               a_is_empty,
  input  logic               b_is_empty,
  input  logic [4:0]         odd_in_a,
  input  logic [4:0]         b_fill,
  output int                 mismatches,
  output int                 outstanding
);

  logic signed [dsm_pkg::DATA_W-1:0] a_mem [DEPTH];
  logic signed [dsm_pkg::DATA_W-1:0] b_mem [DEPTH];
  int a_lvl;
  int b_lvl;
  int odd_lvl;
  int bad_total;
  dsm_pkg::result_t stack_results_due [$];

  initial begin
    bad_total = 0;
  end

  // applies one opcode to the local stacks and returns the result it yields
  function automatic dsm_pkg::result_t apply_stack_op(input logic [2:0] op,
                                                      input logic signed [31:0] val);
    dsm_pkg::result_t r;
    logic signed [dsm_pkg::DATA_W-1:0] v;
    int i;
    int k;
    int pos;
    r = '0;
    r.status = dsm_pkg::ST_OK;
    case (op)
      dsm_pkg::OP_PUSH_A: begin
        if (a_lvl >= DEPTH) r.status = dsm_pkg::ST_FULL;
        else begin
          a_mem[a_lvl] = val;
          a_lvl++;
          if (val[0]) odd_lvl++;
        end
      end
      dsm_pkg::OP_POP_A: begin
        if (a_lvl == 0) r.status = dsm_pkg::ST_EMPTY;
        else begin
          a_lvl--;
          r.popped = a_mem[a_lvl];
          if (r.popped[0] && odd_lvl > 0) odd_lvl--;
        end
      end
      dsm_pkg::OP_PUSH_B: begin
        if (b_lvl >= DEPTH) r.status = dsm_pkg::ST_FULL;
        else begin
          b_mem[b_lvl] = val;
          b_lvl++;
        end
      end
      dsm_pkg::OP_POP_B: begin
        if (b_lvl == 0) r.status = dsm_pkg::ST_EMPTY;
        else begin
          b_lvl--;
          r.popped = b_mem[b_lvl];
        end
      end
      dsm_pkg::OP_MERGE: begin
        // A top to bottom; each even goes just above the topmost B entry >= it
        for (i = a_lvl; i > 0; i--) begin
          v = a_mem[i-1];
          if (!v[0]) begin
            if (b_lvl >= DEPTH) r.status = dsm_pkg::ST_DROP;
            else begin
              pos = 0;
              for (k = b_lvl; k > 0; k--)
                if (pos == 0 && b_mem[k-1] >= v) pos = k;
              for (k = b_lvl; k > pos; k--)
                b_mem[k] = b_mem[k-1];
              b_mem[pos] = v;
              b_lvl++;
            end
          end
        end
      end
      default: ;
    endcase
    r.a_top   = (a_lvl > 0) ? a_mem[a_lvl-1] : '0;
    r.a_empty = (a_lvl == 0);
    r.b_empty = (b_lvl == 0);
    r.odd     = odd_lvl[dsm_pkg::CNT_W-1:0];
    r.bfill   = b_lvl[dsm_pkg::CNT_W-1:0];
    return r;
  endfunction

  function automatic int field_bad(input string name, input longint want,
                                   input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    dsm_pkg::result_t want;
    if (rst) begin
      a_lvl   = 0;
      b_lvl   = 0;
      odd_lvl = 0;
      stack_results_due.delete();
    end else begin
      if (item_valid && !item_stall)
        stack_results_due.push_back(apply_stack_op(opcode, data_value));
      if (result_valid && !result_stall) begin
        if (stack_results_due.size() == 0) begin
          $error("result beat with nothing expected");
          bad_total++;
        end else begin
          want = stack_results_due.pop_front();
          bad_total += field_bad("popped_value", $signed(want.popped), popped_value);
          bad_total += field_bad("status", want.status, status);
          bad_total += field_bad("a_top", $signed(want.a_top), a_top);
          bad_total += field_bad("a_is_empty", want.a_empty, a_is_empty);
          bad_total += field_bad("b_is_empty", want.b_empty, b_is_empty);
          bad_total += field_bad("odd_in_a", want.odd, odd_in_a);
          bad_total += field_bad("b_fill", want.bfill, b_fill);
        end
      end
    end
    mismatches  <= bad_total;
    outstanding <= stack_results_due.size();
  end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Drives opcode beats into the dual stack under random sender gaps and
// receiver stalls; the stack checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int DEPTH     = 16;
  localparam int N_ITEMS   = 1950;
  localparam int QUIET_LEN = 150;

  // opcodes the block treats as no-ops
  localparam logic [2:0] OP_SPARE_LO  = 3'd5;
  localparam logic [2:0] OP_SPARE_MID = 3'd6;
  localparam logic [2:0] OP_SPARE_HI  = 3'd7;

  typedef enum int {DRIVE_FILL, DRIVE_DRAIN, DRIVE_MERGE, DRIVE_MIX} drive_mode_t;

  logic               clk;
  logic               rst          = 1'b1;
  logic               item_valid   = 1'b0;
  logic               item_stall;
  logic [2:0]         opcode       = dsm_pkg::OP_PUSH_A;
  logic signed [31:0] data_value   = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic signed [31:0] popped_value;
  logic [1:0]         status;
  logic signed [31:0] a_top;
  logic               a_is_empty;
  logic               b_is_empty;
  logic [4:0]         odd_in_a;
  logic [4:0]         b_fill;

  int   mismatches;
  int   outstanding;
  logic no_idle = 1'b0;
  int   stall_left = 0;
  int   counted;
  int   seg_len;
  drive_mode_t mode;

  dual_stack_with_sorted_even_merge #(.STACK_DEPTH(DEPTH)) dut (
    .clk, .rst, .item_valid, .item_stall, .opcode, .data_value,
    .result_valid, .result_stall, .popped_value, .status, .a_top,
    .a_is_empty, .b_is_empty, .odd_in_a, .b_fill
  );

  dsm_stack_checker #(.DEPTH(DEPTH)) stack_check (
    .clk, .rst, .item_valid, .item_stall, .opcode, .data_value,
    .result_valid, .result_stall, .popped_value, .status, .a_top,
    .a_is_empty, .b_is_empty, .odd_in_a, .b_fill, .mismatches, .outstanding
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

  // random receiver stalls, held off while no_idle is set
  always @(posedge clk) begin
    if (rst || no_idle) begin
      stall_left   <= 0;
      result_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left   <= stall_left - 1;
      result_stall <= 1'b1;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left   <= $urandom_range(0, 6);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  task automatic send_beat(input logic [2:0] op, input logic signed [31:0] val);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    item_valid <= 1'b1;
    opcode     <= op;
    data_value <= val;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  function automatic logic [2:0] pick_op(input drive_mode_t m);
    int w [5];
    logic [2:0] ops [5];
    int r;
    logic [2:0] op;
    ops = '{dsm_pkg::OP_PUSH_A, dsm_pkg::OP_POP_A, dsm_pkg::OP_PUSH_B,
            dsm_pkg::OP_POP_B, dsm_pkg::OP_MERGE};
    case (m)
      DRIVE_FILL:  w = '{45, 10, 30, 7, 5};
      DRIVE_DRAIN: w = '{10, 40, 7, 35, 5};
      DRIVE_MERGE: w = '{45, 5, 10, 17, 20};
      default:     w = '{25, 20, 20, 20, 12};
    endcase
    if ($urandom_range(0, 99) < 3) return 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    r  = $urandom_range(0, 96);
    op = dsm_pkg::OP_MERGE;
    foreach (w[i]) begin
      if (r >= 0 && r < w[i]) op = ops[i];
      r -= w[i];
    end
    return op;
  endfunction

  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] corners [6];
    corners = '{32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 32'sd0, 32'sd1, -32'sd2};
    case ($urandom_range(0, 5))
      0, 1:    return $urandom_range(0, 16) - 8;  // small values, so ties occur
      2:       return corners[$urandom_range(0, 5)];
      3:       return $urandom() & ~32'd1;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty stacks, extremes, negative odds, ties and spare opcodes
    send_beat(dsm_pkg::OP_POP_A, 32'sd5);
    send_beat(dsm_pkg::OP_POP_B, -32'sd5);
    send_beat(dsm_pkg::OP_MERGE, '0);
    send_beat(dsm_pkg::OP_PUSH_A, 32'sh7FFF_FFFF);
    send_beat(dsm_pkg::OP_PUSH_A, 32'sh8000_0000);
    send_beat(dsm_pkg::OP_PUSH_A, -32'sd1);
    send_beat(dsm_pkg::OP_PUSH_A, -32'sd3);
    send_beat(dsm_pkg::OP_PUSH_A, 32'sd0);
    send_beat(dsm_pkg::OP_PUSH_A, -32'sd2);
    send_beat(dsm_pkg::OP_PUSH_A, 32'sd6);
    send_beat(dsm_pkg::OP_PUSH_A, 32'sd6);
    send_beat(dsm_pkg::OP_PUSH_B, 32'sd100);
    send_beat(dsm_pkg::OP_PUSH_B, 32'sd4);
    send_beat(dsm_pkg::OP_PUSH_B, -32'sd50);
    send_beat(dsm_pkg::OP_MERGE, 32'sd9);
    send_beat(dsm_pkg::OP_POP_B, '0);
    send_beat(dsm_pkg::OP_POP_A, '0);
    send_beat(dsm_pkg::OP_POP_A, '0);
    send_beat(OP_SPARE_LO, 32'sd8);
    send_beat(OP_SPARE_MID, 32'sd8);
    send_beat(OP_SPARE_HI, -32'sd1);
    send_beat(dsm_pkg::OP_PUSH_B, 32'sh5555_5555);
    send_beat(dsm_pkg::OP_PUSH_A, 32'shAAAA_AAAA);
    send_beat(dsm_pkg::OP_MERGE, '0);
    send_beat(dsm_pkg::OP_POP_B, '0);

    counted = 0;
    while (counted < N_ITEMS) begin
      mode    = drive_mode_t'($urandom_range(0, 3));
      seg_len = $urandom_range(20, 80);
      no_idle = ($urandom_range(0, 5) == 0) || (counted >= N_ITEMS - QUIET_LEN);
      repeat (seg_len) begin
        logic [2:0] op;
        op = pick_op(mode);
        send_beat(op, pick_value());
        if (op <= dsm_pkg::OP_MERGE) counted++;
      end
    end

    item_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
